>>> design/ddms_pkg.sv
// shared widths, codes and constants of the drive mixer
package ddms_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int TRIG_W     = 8;
    localparam int STICK_W    = 8;
    localparam int MAX_W      = 10;
    localparam int GAIN_W     = 9;
    localparam int SLEW_W     = 10;
    localparam int TIMEOUT_W  = 16;
    localparam int DRIVE_W    = 11;
    localparam int TURB_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // serial arithmetic sizes
    localparam int PROD_W     = 41;
    localparam int MUL_B_W    = 10;
    localparam int QUO_W      = 12;
    localparam int DIV_D_W    = PROD_W - QUO_W + 1;

    // item operations
    localparam logic [OP_W-1:0] OP_REPORT     = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK       = 2'd1;
    localparam logic [OP_W-1:0] OP_CONNECT    = 2'd2;
    localparam logic [OP_W-1:0] OP_DISCONNECT = 2'd3;

    // turbine command codes
    localparam logic [TURB_W-1:0] TURB_NONE  = 2'd0;
    localparam logic [TURB_W-1:0] TURB_START = 2'd1;
    localparam logic [TURB_W-1:0] TURB_STOP  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_DZ  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_DZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CMD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 3'd5;

    // register reset values
    localparam logic [TRIG_W-1:0]    RST_TRIG_DZ  = 8'd10;
    localparam logic [STICK_W-1:0]   RST_STICK_DZ = 8'd10;
    localparam logic [MAX_W-1:0]     RST_MAX_CMD  = 10'd255;
    localparam logic [GAIN_W-1:0]    RST_GAIN     = 9'd128;
    localparam logic [SLEW_W-1:0]    RST_SLEW     = 10'd10;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT  = 16'd500;

    // divisors: full trigger travel, and full stick cubed times gain one
    localparam logic [DIV_D_W-1:0] TRIG_FULL = 30'd255;
    localparam logic [DIV_D_W-1:0] STEER_DEN = 30'd524386048;

endpackage

>>> design/ddms_if.sv
// handshake channels of the drive mixer: input items, results, register writes
interface ddms_in_if import ddms_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [TRIG_W-1:0]         trigger_forward;
    logic [TRIG_W-1:0]         trigger_reverse;
    logic signed [STICK_W-1:0] stick_x;
    logic                      stop_button;
    logic                      turbine_on_button;
    logic                      turbine_off_button;

    modport source (
        output valid, operation, trigger_forward, trigger_reverse, stick_x,
               stop_button, turbine_on_button, turbine_off_button,
        input  ready
    );
    modport sink (
        input  valid, operation, trigger_forward, trigger_reverse, stick_x,
               stop_button, turbine_on_button, turbine_off_button,
        output ready
    );
endinterface

interface ddms_out_if import ddms_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic [TURB_W-1:0]         turbine_command;

    modport source (
        output valid, left_drive, right_drive, turbine_command,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, turbine_command,
        output ready
    );
endinterface

interface ddms_cfg_if import ddms_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> design/differential_drive_mixer_slew_unit.sv
// top level of the gamepad-to-differential-drive mixer with slew limiting
//
// channels: i_in takes one beat per item (report, tick, connect, disconnect),
// o_out gives exactly one result beat per item (left/right drive levels after
// the item and a one-shot turbine command), i_cfg writes the six registers by
// index and is always ready; write it only while no item is in flight.
// a report runs through one serial multiplier (10 bit steps) and one serial
// divider (12 bit steps): cube of stick, gain, max command, steering divide
// alongside the throttle product, then throttle divide. the next item can be
// taken once the report's result is in the output register. tick, connect and
// disconnect items skip the arithmetic and go straight to the final step.
// one item is worked at a time; a finished result waits in the output
// register while the next item is already accepted and worked on.
// if the receiver stalls, the block holds its next result in the final step
// and takes no new item until the output register frees up.
// reset clears drive levels, turbine latch, link and idle counter, and loads
// the register defaults; no result is pending after reset.
module differential_drive_mixer_slew_unit import ddms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ddms_cfg_if.sink   i_cfg,
    ddms_in_if.sink    i_in,
    ddms_out_if.source o_out
);
    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_CUBE = 4'd3;
    localparam logic [3:0] S_GAIN = 4'd4;
    localparam logic [3:0] S_MAXS = 4'd5;
    localparam logic [3:0] S_DIVS = 4'd6;
    localparam logic [3:0] S_DIVT = 4'd7;
    localparam logic [3:0] S_MIX  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    localparam int MIX_W = QUO_W + 1;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    // slew one level toward its target by at most step
    function automatic logic signed [DRIVE_W-1:0] ramp_level(
        input logic signed [DRIVE_W-1:0] tgt,
        input logic signed [DRIVE_W-1:0] now,
        input logic [SLEW_W-1:0]         step
    );
        logic signed [DRIVE_W:0] t_e;
        logic signed [DRIVE_W:0] n_e;
        logic signed [DRIVE_W:0] s_e;
        logic signed [DRIVE_W:0] d_e;
        logic signed [DRIVE_W:0] res;
        t_e = {tgt[DRIVE_W-1], tgt};
        n_e = {now[DRIVE_W-1], now};
        s_e = signed'((DRIVE_W+1)'(step));
        d_e = t_e - n_e;
        if (d_e > s_e) begin
            res = n_e + s_e;
        end else if (d_e < -s_e) begin
            res = n_e - s_e;
        end else begin
            res = t_e;
        end
        return res[DRIVE_W-1:0];
    endfunction

    // clamp a mixed target to +/- max command
    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [MIX_W-1:0] v,
        input logic [MAX_W-1:0]        lim
    );
        logic signed [MIX_W-1:0] l_e;
        logic signed [MIX_W-1:0] res;
        l_e = signed'(MIX_W'(lim));
        if (v > l_e) begin
            res = l_e;
        end else if (v < -l_e) begin
            res = -l_e;
        end else begin
            res = v;
        end
        return res[DRIVE_W-1:0];
    endfunction

    // configuration registers
    logic [TRIG_W-1:0]    r_trig_dz;
    logic [STICK_W-1:0]   r_stick_dz;
    logic [MAX_W-1:0]     r_max;
    logic [GAIN_W-1:0]    r_gain;
    logic [SLEW_W-1:0]    r_slew;
    logic [TIMEOUT_W-1:0] r_timeout;

    // block state
    logic signed [DRIVE_W-1:0] r_left,  n_left;
    logic signed [DRIVE_W-1:0] r_right, n_right;
    logic                      r_turb_run, n_turb_run;
    logic                      r_link, n_link;
    logic [TIMEOUT_W-1:0]      r_idle, n_idle;
    logic [TURB_W-1:0]         n_code;
    logic [TIMEOUT_W-1:0]      idle_inc;

    // sequencer and captured item
    logic [3:0]                r_state, n_state;
    logic [OP_W-1:0]           r_op;
    logic                      r_stop;
    logic                      r_on;
    logic                      r_off;
    logic [TRIG_W-1:0]         r_dmag;
    logic                      r_dneg;
    logic [STICK_W-1:0]        r_ax;
    logic                      r_xneg;
    logic [QUO_W-1:0]          r_steer_mag;
    logic [MAX_W-1:0]          r_thr_mag;
    logic signed [DRIVE_W-1:0] r_tl;
    logic signed [DRIVE_W-1:0] r_tr;

    // output register
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_left;
    logic signed [DRIVE_W-1:0] r_out_right;
    logic [TURB_W-1:0]         r_out_code;

    // arithmetic units
    logic                mul_start, mul_done;
    logic [PROD_W-1:0]   mul_a, mul_p;
    logic [MUL_B_W-1:0]  mul_b;
    logic                div_start, div_done;
    logic [PROD_W-1:0]   div_num;
    logic [DIV_D_W-1:0]  div_den;
    logic [QUO_W-1:0]    div_q;

    // front end of a report: deadzones, trigger difference, stick magnitude
    logic                   in_acc;
    logic [TRIG_W-1:0]      fwd_eff;
    logic [TRIG_W-1:0]      rev_eff;
    logic [TRIG_W:0]        diff;
    logic [TRIG_W:0]        diff_neg;
    logic [STICK_W:0]       x_ext;
    logic [STICK_W:0]       ax_ext;
    logic [STICK_W-1:0]     ax_eff;

    // mixing of the targets
    logic                    thr_neg;
    logic signed [MIX_W-1:0] thr_s;
    logic signed [MIX_W-1:0] steer_s;
    logic signed [MIX_W-1:0] mix_l;
    logic signed [MIX_W-1:0] mix_r;

    logic out_free;
    logic fin;

    ddms_smul #(.P_W(PROD_W), .B_W(MUL_B_W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    ddms_sdiv #(.N_W(PROD_W), .Q_W(QUO_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_q     (div_q)
    );

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_dz  <= RST_TRIG_DZ;
            r_stick_dz <= RST_STICK_DZ;
            r_max      <= RST_MAX_CMD;
            r_gain     <= RST_GAIN;
            r_slew     <= RST_SLEW;
            r_timeout  <= RST_TIMEOUT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TRIG_DZ:  r_trig_dz  <= i_cfg.data[TRIG_W-1:0];
                REG_STICK_DZ: r_stick_dz <= i_cfg.data[STICK_W-1:0];
                REG_MAX_CMD:  r_max      <= i_cfg.data[MAX_W-1:0];
                REG_GAIN:     r_gain     <= i_cfg.data[GAIN_W-1:0];
                REG_SLEW:     r_slew     <= i_cfg.data[SLEW_W-1:0];
                REG_TIMEOUT:  r_timeout  <= i_cfg.data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // one item at a time
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);

    always_comb begin
        fwd_eff  = (i_in.trigger_forward < r_trig_dz) ? '0 : i_in.trigger_forward;
        rev_eff  = (i_in.trigger_reverse < r_trig_dz) ? '0 : i_in.trigger_reverse;
        diff     = {1'b0, fwd_eff} - {1'b0, rev_eff};
        diff_neg = '0 - diff;
        x_ext    = {i_in.stick_x[STICK_W-1], i_in.stick_x};
        // magnitude fits 8 unsigned bits, full negative stick gives 128
        ax_ext   = i_in.stick_x[STICK_W-1] ? ('0 - x_ext) : x_ext;
        ax_eff   = (ax_ext[STICK_W-1:0] < r_stick_dz) ? '0 : ax_ext[STICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_in.operation;
            r_stop <= i_in.stop_button;
            r_on   <= i_in.turbine_on_button;
            r_off  <= i_in.turbine_off_button;
            r_dneg <= diff[TRIG_W];
            r_dmag <= diff[TRIG_W] ? diff_neg[TRIG_W-1:0] : diff[TRIG_W-1:0];
            r_xneg <= i_in.stick_x[STICK_W-1];
            r_ax   <= ax_eff;
        end
    end

    // sequencer: steering product |x|^3 * gain * max, then steering divide
    // while the throttle product |d| * max runs, then throttle divide
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = mul_p;
        mul_b     = MUL_B_W'(r_ax);
        div_start = 1'b0;
        div_num   = mul_p;
        div_den   = STEER_DEN;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in.operation == OP_REPORT) ? S_PREP : S_FIN;
                end
            end
            S_PREP: begin
                mul_start = 1'b1;
                mul_a     = PROD_W'(r_ax);
                n_state   = S_SQ;
            end
            S_SQ: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_state   = S_CUBE;
                end
            end
            S_CUBE: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_b     = MUL_B_W'(r_gain);
                    n_state   = S_GAIN;
                end
            end
            S_GAIN: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_b     = MUL_B_W'(r_max);
                    n_state   = S_MAXS;
                end
            end
            S_MAXS: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    mul_start = 1'b1;
                    mul_a     = PROD_W'(r_dmag);
                    mul_b     = MUL_B_W'(r_max);
                    n_state   = S_DIVS;
                end
            end
            S_DIVS: begin
                // throttle product is done before this quotient
                if (div_done) begin
                    div_start = 1'b1;
                    div_den   = TRIG_FULL;
                    n_state   = S_DIVT;
                end
            end
            S_DIVT: begin
                if (div_done) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIVS && div_done) begin
            r_steer_mag <= div_q;
        end
        if (r_state == S_DIVT && div_done) begin
            r_thr_mag <= div_q[MAX_W-1:0];
        end
    end

    // steering flips with throttle only when truncated throttle is negative
    always_comb begin
        thr_neg = r_dneg && (r_thr_mag != '0);
        thr_s   = thr_neg ? -signed'(MIX_W'(r_thr_mag)) : signed'(MIX_W'(r_thr_mag));
        steer_s = (r_xneg ^ thr_neg) ? -signed'(MIX_W'(r_steer_mag))
                                     : signed'(MIX_W'(r_steer_mag));
        mix_l   = thr_s - steer_s;
        mix_r   = thr_s + steer_s;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MIX) begin
            r_tl <= clamp_sym(mix_l, r_max);
            r_tr <= clamp_sym(mix_r, r_max);
        end
    end

    // final step: state update and result, when the output register is free
    assign out_free = !r_out_valid || o_out.ready;
    assign fin      = (r_state == S_FIN) && out_free;

    always_comb begin
        n_left     = r_left;
        n_right    = r_right;
        n_turb_run = r_turb_run;
        n_link     = r_link;
        n_idle     = r_idle;
        n_code     = TURB_NONE;
        idle_inc   = (r_idle == '1) ? r_idle : r_idle + 1'b1;
        unique case (r_op)
            OP_REPORT: begin
                n_idle = '0;
                // start wins when both buttons are held
                if (r_on) begin
                    if (!r_turb_run) begin
                        n_turb_run = 1'b1;
                        n_code     = TURB_START;
                    end
                end else if (r_off) begin
                    if (r_turb_run) begin
                        n_turb_run = 1'b0;
                        n_code     = TURB_STOP;
                    end
                end
                if (r_stop) begin
                    n_left  = '0;
                    n_right = '0;
                end else begin
                    n_left  = ramp_level(r_tl, r_left, r_slew);
                    n_right = ramp_level(r_tr, r_right, r_slew);
                end
            end
            OP_TICK: begin
                if (!r_link) begin
                    n_left  = '0;
                    n_right = '0;
                end else if (idle_inc > r_timeout) begin
                    n_left  = '0;
                    n_right = '0;
                    n_idle  = '0;
                end else begin
                    n_idle  = idle_inc;
                end
            end
            OP_CONNECT: begin
                n_link = 1'b1;
                n_idle = '0;
            end
            OP_DISCONNECT: begin
                n_link  = 1'b0;
                n_left  = '0;
                n_right = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right     <= '0;
            r_turb_run  <= 1'b0;
            r_link      <= 1'b0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin) begin
                r_left      <= n_left;
                r_right     <= n_right;
                r_turb_run  <= n_turb_run;
                r_link      <= n_link;
                r_idle      <= n_idle;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out_left  <= n_left;
            r_out_right <= n_right;
            r_out_code  <= n_code;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.left_drive      = r_out_left;
    assign o_out.right_drive     = r_out_right;
    assign o_out.turbine_command = r_out_code;

    // arithmetic units only finish while a report is being worked
    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !(mul_done || div_done))
        else $error("arithmetic unit finished with no report in flight");

    // only reports may carry a turbine command
    a_code_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin && (r_op != OP_REPORT)) |-> (n_code == TURB_NONE))
        else $error("turbine command on a non-report item");

    // drive levels stay inside the symmetric range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != DRIVE_MIN) && (r_right != DRIVE_MIN))
        else $error("drive level left the symmetric range");

    // a finished item leaves a pending result and frees the input side
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished item did not produce a result");
endmodule

>>> design/ddms_smul.sv
// serial shift-add multiplier, one multiplier bit per cycle
module ddms_smul import ddms_pkg::*; #(
    parameter int P_W = PROD_W,
    parameter int B_W = MUL_B_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [P_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [P_W-1:0] o_p
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [P_W-1:0]   r_a;
    logic [B_W-1:0]   r_b;
    logic [P_W-1:0]   r_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(B_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product added when the low multiplier bit is set
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule

>>> design/ddms_sdiv.sv
// serial restoring divider, one quotient bit per cycle
module ddms_sdiv import ddms_pkg::*; #(
    parameter int N_W = PROD_W,
    parameter int Q_W = QUO_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [N_W-1:0]       i_num,
    input  logic [N_W-Q_W:0]     i_den,
    output logic                 o_done,
    output logic [Q_W-1:0]       o_q
);
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_d;
    logic [Q_W-1:0]   r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // divisor starts aligned to the top quotient bit and walks down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_d   <= {i_den, {(Q_W-1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_d) begin
                r_rem <= r_rem - r_d;
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
            r_d <= r_d >> 1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
